[src/rapd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rapd_pkg
// Types, codes and constants shared by the afterglow pixel decay block.
// ----------------------------------------------------------------------------
package rapd_pkg;

    localparam int COLOR_BITS  = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LAYER_LIMIT = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic PLANE_MAIN   = 1'b0;
    localparam logic PLANE_WINDOW = 1'b1;

    localparam logic [1:0] TSEL_NORMAL = 2'd0;
    localparam logic [1:0] TSEL_TAIL   = 2'd1;
    localparam logic [1:0] TSEL_WINDOW = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_WEIGHT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_DECAY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_ENABLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_GATE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_ENABLE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ENABLE = 3'd5;

    typedef logic [COLOR_BITS-1:0] t_color;

    // color table access, one item per cycle
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [1:0]        sel;
        logic [ADDR_W-1:0] addr;
        t_color            data;
    } t_tab_req;

    typedef struct packed {
        t_color norm;
        t_color tail;
        t_color win;
    } t_tab_rd;

    // pixel item after the decay stage
    typedef struct packed {
        logic              is_load;
        logic              skip;
        logic              plane;
        logic              use_tail;
        logic [ADDR_W-1:0] addr;
        logic              nm;
        logic              fb_ok;
        logic              map_xor;
        logic [15:0]       map_color;
        logic [1:0]        tsel;
        t_color            tval;
    } t_stage;

    function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
        sat_sub8 = (a > b) ? (a - b) : 8'd0;
    endfunction

endpackage
`default_nettype wire

[src/rapd_ctab.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rapd_ctab
// Normal, tail and window color tables, one write and one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module rapd_ctab
    import rapd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_tab_req i_req,
    output t_tab_rd       o_rd
);

    t_color r_mem_norm [TABLE_DEPTH];
    t_color r_mem_tail [TABLE_DEPTH];
    t_color r_mem_win  [TABLE_DEPTH];
    t_tab_rd r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            case (i_req.sel)
                TSEL_NORMAL: r_mem_norm[i_req.addr] <= i_req.data;
                TSEL_TAIL:   r_mem_tail[i_req.addr] <= i_req.data;
                TSEL_WINDOW: r_mem_win[i_req.addr]  <= i_req.data;
                default: ;
            endcase
        end
        if (i_req.rd_en) begin
            r_rd.norm <= r_mem_norm[i_req.addr];
            r_rd.tail <= r_mem_tail[i_req.addr];
            r_rd.win  <= r_mem_win[i_req.addr];
        end
    end

    assign o_rd = r_rd;

endmodule
`default_nettype wire

[src/radar_afterglow_pixel_decay.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radar_afterglow_pixel_decay
// Afterglow decay of one radar display pixel per item, with color lookup.
//
// Input stream: one item per pixel visit (opcode pixel) or per color table
// load (opcode load). Output stream: one result item per input item, in order.
// Configuration port: index/data writes, always ready, to be used while idle.
// Pipeline: decay stage, color table read stage, output register. An item
// is registered in stage A, then in stage B with its table read data, then
// at the output; one item per cycle is sustained while results are taken.
// A table load is written in the table read stage, so a pixel item accepted
// right after it already sees the new entry.
// Reset clears the stage valid bits and loads the register defaults; the
// color tables are not cleared and must be loaded before use.
// When the receiver stalls, the result holds, empty stages fill up, and
// s_axis_tready drops once all three stages hold an item.
// ----------------------------------------------------------------------------
module radar_afterglow_pixel_decay
    import rapd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tdata: intensity[7:0], tail_mark[8], layer_level[10:9], map_flag[11],
    //        map_color[27:12], table_index[35:28], table_value[51:36], zeros
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode[0], plane[1], table_select[3:2]
    input  wire logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: new_intensity[7:0], new_tail_mark[8], pixel_color[24:9],
    //        fb_value[40:25], zeros
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: color_valid[0], fb_write[1]
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [7:0] r_decay_weight;
    logic [7:0] r_tail_decay;
    logic       r_tail_enable;
    logic [7:0] r_tail_gate;
    logic       r_decay_enable;
    logic       r_window_enable;

    logic   r_a_valid, r_b_valid, r_c_valid;
    t_stage r_a, r_b, n_a;
    logic [OUT_TDATA_W-1:0] r_c_data, n_c_data;
    logic [OUT_TUSER_W-1:0] r_c_user, n_c_user;

    logic adv_a, adv_b, adv_c;
    t_tab_req tab_req;
    t_tab_rd  tab_rd;

    // input fields
    logic        in_op, in_plane, in_mark, in_mflag;
    logic [7:0]  in_inten, in_tidx;
    logic [1:0]  in_layer, in_tsel;
    logic [15:0] in_mcolor, in_tval;

    assign in_op     = i_s_axis_tuser[0];
    assign in_plane  = i_s_axis_tuser[1];
    assign in_tsel   = i_s_axis_tuser[3:2];
    assign in_inten  = i_s_axis_tdata[7:0];
    assign in_mark   = i_s_axis_tdata[8];
    assign in_layer  = i_s_axis_tdata[10:9];
    assign in_mflag  = i_s_axis_tdata[11];
    assign in_mcolor = i_s_axis_tdata[27:12];
    assign in_tidx   = i_s_axis_tdata[35:28];
    assign in_tval   = i_s_axis_tdata[51:36];

    // flow control
    assign adv_c = !r_c_valid || i_m_axis_tready;
    assign adv_b = !r_b_valid || adv_c;
    assign adv_a = !r_a_valid || adv_b;
    assign o_s_axis_tready = adv_a;
    assign o_cfg_ready     = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_weight  <= 8'd60;
            r_tail_decay    <= 8'd20;
            r_tail_enable   <= 1'b1;
            r_tail_gate     <= 8'd200;
            r_decay_enable  <= 1'b1;
            r_window_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DECAY_WEIGHT:  r_decay_weight  <= i_cfg_data;
                CFG_TAIL_DECAY:    r_tail_decay    <= i_cfg_data;
                CFG_TAIL_ENABLE:   r_tail_enable   <= i_cfg_data[0];
                CFG_TAIL_GATE:     r_tail_gate     <= i_cfg_data;
                CFG_DECAY_ENABLE:  r_decay_enable  <= i_cfg_data[0];
                CFG_WINDOW_ENABLE: r_window_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage A: decay
    always_comb begin
        logic [7:0] ni_norm, ni_tail;
        ni_norm = sat_sub8(in_inten, r_decay_weight);
        ni_tail = sat_sub8(in_inten, r_tail_decay);

        n_a.is_load   = (in_op == OP_LOAD);
        n_a.skip      = !r_decay_enable || (in_plane == PLANE_WINDOW && !r_window_enable)
                        || (in_inten == 8'd0);
        n_a.plane     = in_plane;
        n_a.use_tail  = 1'b0;
        n_a.addr      = ni_norm;
        n_a.nm        = in_mark;
        n_a.fb_ok     = (in_layer < 2'(LAYER_LIMIT));
        n_a.map_xor   = (in_plane == PLANE_MAIN) && in_mflag;
        n_a.map_color = in_mcolor;
        n_a.tsel      = in_tsel;
        n_a.tval      = COLOR_BITS'(in_tval);

        if (n_a.is_load) begin
            n_a.addr = in_tidx;
        end else if (n_a.skip) begin
            n_a.addr = in_inten;
        end else if (r_tail_enable) begin
            if (in_mark) begin
                n_a.addr     = ni_tail;
                n_a.use_tail = 1'b1;
                if (ni_tail == 8'd0) begin
                    n_a.nm = 1'b0;
                end
            end else if (in_inten > r_tail_gate && ni_norm < r_tail_gate) begin
                n_a.use_tail = 1'b1;
                n_a.nm       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv_a) begin
            r_a_valid <= i_s_axis_tvalid;
        end
        if (adv_a) begin
            r_a <= n_a;
        end
    end

    // stage B: color table write or read
    always_comb begin
        tab_req.rd_en = adv_b && r_a_valid && !r_a.is_load;
        tab_req.wr_en = adv_b && r_a_valid && r_a.is_load;
        tab_req.sel   = r_a.tsel;
        tab_req.addr  = r_a.addr;
        tab_req.data  = r_a.tval;
    end

    rapd_ctab u_ctab (
        .i_clk (i_clk),
        .i_req (tab_req),
        .o_rd  (tab_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv_b) begin
            r_b_valid <= r_a_valid;
        end
        if (adv_b) begin
            r_b <= r_a;
        end
    end

    // stage C: color select, frame buffer value
    always_comb begin
        t_color      color;
        logic [15:0] color16, fbv;
        if (r_b.use_tail) begin
            color = tab_rd.tail;
        end else if (r_b.plane == PLANE_MAIN) begin
            color = tab_rd.norm;
        end else begin
            color = tab_rd.win;
        end
        color16 = 16'(color);
        fbv     = color16 ^ (r_b.map_xor ? r_b.map_color : 16'd0);

        n_c_data = '0;
        n_c_user = '0;
        if (!r_b.is_load) begin
            n_c_data[7:0] = r_b.addr;
            n_c_data[8]   = r_b.nm;
            if (!r_b.skip) begin
                n_c_data[24:9] = color16;
                n_c_user[0]    = 1'b1;
                if (r_b.fb_ok) begin
                    n_c_user[1]     = 1'b1;
                    n_c_data[40:25] = fbv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv_c) begin
            r_c_valid <= r_b_valid;
        end
        if (adv_c) begin
            r_c_data <= n_c_data;
            r_c_user <= n_c_user;
        end
    end

    assign o_m_axis_tvalid = r_c_valid;
    assign o_m_axis_tdata  = r_c_data;
    assign o_m_axis_tuser  = r_c_user;

    // assertions
    a_fb_needs_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0]
            |-> !o_m_axis_tuser[1] && o_m_axis_tdata[40:9] == 32'd0)
        else $error("frame buffer write or color on an unprocessed item");

    a_stage_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !adv_c |=> r_b_valid && $stable(r_b))
        else $error("table stage item lost or changed during stall");

    a_one_table_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tab_req.rd_en && tab_req.wr_en))
        else $error("table read and write in the same cycle");

    a_in_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_a_valid && r_b_valid && r_c_valid && !i_m_axis_tready)
        else $error("input stalled while the pipeline has room");

endmodule
`default_nettype wire

[verif/rapd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rapd_checker
// Watches the pixel, result and register channels of the afterglow decay
// block, keeps its own copy of the registers and the three color tables,
// predicts each result item in order and compares it field by field.
// ----------------------------------------------------------------------------
module rapd_checker
    import rapd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  wire logic [IN_TUSER_W-1:0]  i_in_tuser,
    input  wire logic                   i_in_tvalid,
    input  wire logic                   i_in_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  wire logic [OUT_TUSER_W-1:0] i_out_tuser,
    input  wire logic                   i_out_tvalid,
    input  wire logic                   i_out_tready,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_pending,
    output int                          o_errors
);

    typedef struct packed {
        logic        opcode;
        logic        plane;
        logic [1:0]  tsel;
        logic [7:0]  inten;
        logic        mark;
        logic [1:0]  layer;
        logic        mflag;
        logic [15:0] mcolor;
        logic [7:0]  tidx;
        t_color      tval;
    } t_pix_item;

    typedef struct packed {
        logic [7:0] ni;
        logic       nm;
        t_color     color;
        logic       cvalid;
        logic       fbw;
        t_color     fbv;
    } t_pix_result;

    logic [7:0] weight   = 8'd60;
    logic [7:0] tail_dec = 8'd20;
    logic       tail_en  = 1'b1;
    logic [7:0] gate     = 8'd200;
    logic       decay_en = 1'b1;
    logic       win_en   = 1'b1;

    t_color norm_tab [TABLE_DEPTH];
    t_color tail_tab [TABLE_DEPTH];
    t_color win_tab  [TABLE_DEPTH];

    t_pix_result decayed_q [$];
    int          err_cnt = 0;

    function automatic t_pix_result decay_pixel(input t_pix_item it);
        t_pix_result r;
        logic        tail_lut;
        r        = '0;
        r.ni     = it.inten;
        r.nm     = it.mark;
        tail_lut = 1'b0;
        if (!decay_en || (it.plane == PLANE_WINDOW && !win_en) || it.inten == 8'd0)
            return r;
        if (tail_en && it.mark) begin
            r.ni     = (it.inten > tail_dec) ? it.inten - tail_dec : 8'd0;
            tail_lut = 1'b1;
            if (r.ni == 8'd0)
                r.nm = 1'b0;
        end else begin
            r.ni = (it.inten > weight) ? it.inten - weight : 8'd0;
            if (tail_en && it.inten > gate && r.ni < gate) begin
                tail_lut = 1'b1;
                r.nm     = 1'b1;
            end
        end
        if (tail_lut)
            r.color = tail_tab[r.ni];
        else if (it.plane == PLANE_MAIN)
            r.color = norm_tab[r.ni];
        else
            r.color = win_tab[r.ni];
        r.cvalid = 1'b1;
        if (it.layer < LAYER_LIMIT) begin
            r.fbw = 1'b1;
            r.fbv = r.color ^ ((it.plane == PLANE_MAIN && it.mflag) ? it.mcolor : 16'h0);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pix_item   it;
        t_pix_result want;
        t_pix_result got;
        if (!i_rst_n) begin
            weight   = 8'd60;
            tail_dec = 8'd20;
            tail_en  = 1'b1;
            gate     = 8'd200;
            decay_en = 1'b1;
            win_en   = 1'b1;
            decayed_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got.ni     = i_out_tdata[7:0];
                got.nm     = i_out_tdata[8];
                got.color  = i_out_tdata[24:9];
                got.fbv    = i_out_tdata[40:25];
                got.cvalid = i_out_tuser[0];
                got.fbw    = i_out_tuser[1];
                if (decayed_q.size() == 0) begin
                    $error("result item with no item pending");
                    err_cnt++;
                end else begin
                    want = decayed_q.pop_front();
                    check_field("new_intensity", 16'(want.ni), 16'(got.ni));
                    check_field("new_tail_mark", 16'(want.nm), 16'(got.nm));
                    check_field("pixel_color", 16'(want.color), 16'(got.color));
                    check_field("color_valid", 16'(want.cvalid), 16'(got.cvalid));
                    check_field("fb_write", 16'(want.fbw), 16'(got.fbw));
                    check_field("fb_value", 16'(want.fbv), 16'(got.fbv));
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                it.opcode = i_in_tuser[0];
                it.plane  = i_in_tuser[1];
                it.tsel   = i_in_tuser[3:2];
                it.inten  = i_in_tdata[7:0];
                it.mark   = i_in_tdata[8];
                it.layer  = i_in_tdata[10:9];
                it.mflag  = i_in_tdata[11];
                it.mcolor = i_in_tdata[27:12];
                it.tidx   = i_in_tdata[35:28];
                it.tval   = i_in_tdata[51:36];
                if (it.opcode == OP_LOAD) begin
                    case (it.tsel)
                        TSEL_NORMAL: norm_tab[it.tidx] = it.tval;
                        TSEL_TAIL:   tail_tab[it.tidx] = it.tval;
                        TSEL_WINDOW: win_tab[it.tidx]  = it.tval;
                        default: ;
                    endcase
                    want = '0;
                    decayed_q.push_back(want);
                end else begin
                    decayed_q.push_back(decay_pixel(it));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DECAY_WEIGHT:  weight   = i_cfg_data;
                    CFG_TAIL_DECAY:    tail_dec = i_cfg_data;
                    CFG_TAIL_ENABLE:   tail_en  = i_cfg_data[0];
                    CFG_TAIL_GATE:     gate     = i_cfg_data;
                    CFG_DECAY_ENABLE:  decay_en = i_cfg_data[0];
                    CFG_WINDOW_ENABLE: win_en   = i_cfg_data[0];
                    default: ;
                endcase
            end
            o_pending <= decayed_q.size();
        end
        o_errors <= err_cnt;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Afterglow pixel decay testbench: fills the color tables, runs a directed
// set of pixel visits and loads, then random pixel and load items over several
// register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb
    import rapd_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    // table select that names no table
    localparam logic [1:0] TSEL_BAD = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     pending;
    int                     errors;

    // register copy used to aim intensities at the interesting bands
    logic [7:0] cur_weight = 8'd60;
    logic [7:0] cur_tdecay = 8'd20;
    logic [7:0] cur_gate   = 8'd200;

    int   burst_left = 0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;
    int   rx_mode    = 0;
    int   mode_left  = 0;
    logic [1:0] rx_tick = '0;
    int   idle_cycles = 0;

    always #5 clk = ~clk;

    radar_afterglow_pixel_decay dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    rapd_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tdata   (s_tdata),
        .i_in_tuser   (s_tuser),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    // receiver: changing stall patterns, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(50, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            rx_tick <= rx_tick + 2'd1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_tick == 2'd0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_item(input logic [IN_TUSER_W-1:0] user,
                             input logic [IN_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
            if (gap > 0 && s_tvalid) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tuser  <= user;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_pixel(input logic plane, input logic [7:0] inten,
                              input logic mark, input logic [1:0] layer,
                              input logic mflag, input logic [15:0] mcolor);
        logic [15:0] junk_v;
        logic [7:0]  junk_i;
        logic [1:0]  junk_s;
        junk_v = 16'($urandom_range(0, 65535));
        junk_i = 8'($urandom_range(0, 255));
        junk_s = 2'($urandom_range(0, 3));
        push_item({junk_s, plane, OP_PIXEL},
                  {4'b0, junk_v, junk_i, mcolor, mflag, layer, mark, inten});
    endtask

    task automatic send_load(input logic [1:0] tsel, input logic [7:0] idx,
                             input logic [15:0] val);
        logic [15:0] junk_c;
        logic [7:0]  junk_n;
        logic [3:0]  junk_f;
        logic        junk_p;
        junk_c = 16'($urandom_range(0, 65535));
        junk_n = 8'($urandom_range(0, 255));
        junk_f = 4'($urandom_range(0, 15));
        junk_p = 1'($urandom_range(0, 1));
        push_item({tsel, junk_p, OP_LOAD}, {4'b0, val, idx, junk_c, junk_f, junk_n});
    endtask

    function automatic logic [7:0] pick_intensity();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
            v = 0;
        else if (r < 18)
            v = 255;
        else if (r < 55)
            v = cur_gate + $urandom_range(0, cur_weight + 1);
        else if (r < 75)
            v = $urandom_range(1, cur_tdecay + 2);
        else
            v = $urandom_range(0, 255);
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic send_random_item();
        logic [1:0] tsel;
        if ($urandom_range(0, 99) < 15) begin
            tsel = 2'($urandom_range(0, 3));
            send_load(tsel, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end else begin
            send_pixel(1'($urandom_range(0, 1)), pick_intensity(),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] weight, input logic [7:0] tdecay,
                              input logic tail_en, input logic [7:0] gate,
                              input logic decay_en, input logic win_en);
        write_reg(CFG_DECAY_WEIGHT, weight);
        write_reg(CFG_TAIL_DECAY, tdecay);
        write_reg(CFG_TAIL_ENABLE, {7'b0, tail_en});
        write_reg(CFG_TAIL_GATE, gate);
        write_reg(CFG_DECAY_ENABLE, {7'b0, decay_en});
        write_reg(CFG_WINDOW_ENABLE, {7'b0, win_en});
        cfg_valid  <= 1'b0;
        cur_weight = weight;
        cur_tdecay = tdecay;
        cur_gate   = gate;
    endtask

    task automatic run_random(input int n);
        repeat (n) send_random_item();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(8'd60, 8'd20, 1'b1, 8'd200, 1'b1, 1'b1);

        // every table entry is written before any pixel can read it
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_load(TSEL_NORMAL, i[7:0], 16'($urandom_range(0, 65535)));
            send_load(TSEL_TAIL, i[7:0], 16'($urandom_range(0, 65535)));
            send_load(TSEL_WINDOW, i[7:0], 16'($urandom_range(0, 65535)));
        end

        // directed visits at reset register values
        send_pixel(PLANE_MAIN, 8'd0, 1'b1, 2'd0, 1'b1, 16'hffff);
        send_pixel(PLANE_MAIN, 8'd255, 1'b0, 2'd0, 1'b1, 16'hffff);
        send_pixel(PLANE_MAIN, 8'd210, 1'b0, 2'd1, 1'b0, 16'h1234);
        send_pixel(PLANE_MAIN, 8'd200, 1'b0, 2'd0, 1'b1, 16'h0f0f);
        send_pixel(PLANE_MAIN, 8'd201, 1'b0, 2'd0, 1'b1, 16'h8001);
        send_pixel(PLANE_MAIN, 8'd100, 1'b0, 2'd1, 1'b1, 16'haaaa);
        send_pixel(PLANE_MAIN, 8'd30, 1'b0, 2'd0, 1'b0, 16'h5555);
        send_pixel(PLANE_MAIN, 8'd15, 1'b1, 2'd0, 1'b1, 16'h00ff);
        send_pixel(PLANE_MAIN, 8'd20, 1'b1, 2'd1, 1'b0, 16'h0000);
        send_pixel(PLANE_MAIN, 8'd255, 1'b1, 2'd0, 1'b1, 16'hff00);
        send_pixel(PLANE_WINDOW, 8'd120, 1'b0, 2'd0, 1'b1, 16'hffff);
        send_pixel(PLANE_WINDOW, 8'd50, 1'b1, 2'd1, 1'b1, 16'hffff);
        send_pixel(PLANE_WINDOW, 8'd230, 1'b0, 2'd0, 1'b0, 16'h0001);
        send_pixel(PLANE_WINDOW, 8'd0, 1'b0, 2'd3, 1'b1, 16'hffff);
        send_pixel(PLANE_MAIN, 8'd150, 1'b0, 2'd2, 1'b1, 16'hffff);
        send_pixel(PLANE_MAIN, 8'd150, 1'b1, 2'd3, 1'b1, 16'hffff);
        // select 3 writes nothing: the tail entry read next must be unchanged
        send_load(TSEL_BAD, 8'd195, 16'hffff);
        send_pixel(PLANE_MAIN, 8'd255, 1'b0, 2'd0, 1'b0, 16'h0000);
        // a load is seen by the pixel right behind it
        send_load(TSEL_NORMAL, 8'd40, 16'hbeef);
        send_pixel(PLANE_MAIN, 8'd100, 1'b0, 2'd0, 1'b1, 16'h0001);
        send_load(TSEL_WINDOW, 8'd0, 16'h0000);
        send_pixel(PLANE_WINDOW, 8'd1, 1'b0, 2'd0, 1'b0, 16'h0000);

        // reset values, with the long receiver hold-off
        run_random(40);
        hold_req <= 1'b1;
        run_random(220);
        drain();

        set_config(8'd0, 8'd0, 1'b1, 8'd0, 1'b1, 1'b1);
        run_random(120);
        drain();
        set_config(8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 1'b1);
        run_random(120);
        drain();
        set_config(8'd30, 8'd10, 1'b0, 8'd120, 1'b1, 1'b1);
        run_random(120);
        drain();
        set_config(8'd60, 8'd20, 1'b1, 8'd200, 1'b0, 1'b1);
        run_random(60);
        drain();
        set_config(8'd40, 8'd15, 1'b1, 8'd180, 1'b1, 1'b0);
        run_random(120);
        drain();
        repeat (4) begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 3) != 0), 8'($urandom_range(0, 255)),
                       1'b1, ($urandom_range(0, 3) != 0));
            run_random(90);
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
src/rapd_pkg.sv
src/rapd_ctab.sv
src/radar_afterglow_pixel_decay.sv
verif/rapd_checker.sv
verif/tb.sv
